### sv/uws_pkg.sv
`default_nettype none

package uws_pkg;

    // default width of the saturating counters
    localparam int unsigned COUNT_WIDTH_DEF = 32;

    // width of a decoded code point and of a reported count
    localparam int unsigned CP_W  = 21;
    localparam int unsigned OUT_W = 32;

    // one decoder event toward the word machine
    typedef struct packed {
        logic            valid;  // event present this cycle
        logic            is_end; // end of text: report and clear
        logic [CP_W-1:0] cp;     // completed code point when not end
    } t_cp_evt;

    // result fields toward the output register
    typedef struct packed {
        logic [OUT_W-1:0] consonant_end_words;
        logic [OUT_W-1:0] vowel_start_words;
        logic [OUT_W-1:0] word_total;
    } t_result;

endpackage

`default_nettype wire

### sv/utf8_word_statistics_top.sv
`default_nettype none

// UTF-8 word statistics. Bytes of text enter on the slave stream with tuser
// low; each is decoded into code points (lead byte sets a length of one to
// four, continuation bytes are not checked, an invalid lead byte is
// dropped) and a word machine counts words, words starting with a vowel and
// words whose last character is a consonant when a delimiter closes them.
// A transfer with tuser high marks the end of text: it produces one result
// transfer with the three counts (saturating, clamped to 32 bits) and
// clears all state; data bytes produce no result. One transfer is accepted
// every clock cycle while the input is not stalled. The result is offered
// on the master side once the accepted end-of-text transfer has passed the
// decoder register and the output register has then been loaded from the
// counters at the same edge as the word machine clears. The input stalls only
// while a result is held in the output register and the master side is not
// ready.
module utf8_word_statistics_top #(
    parameter int unsigned COUNT_WIDTH = uws_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic        i_s_axis_tuser,   // [0] action
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [95:0]      o_m_axis_tdata    // [31:0] word_total,
                                               // [63:32] vowel_start_words,
                                               // [95:64] consonant_end_words
);

    logic             en;
    logic             take;
    uws_pkg::t_cp_evt evt;
    logic             out_valid;
    uws_pkg::t_result result;

    // whole pipeline advances unless a held result is not taken
    assign en              = !out_valid || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign take            = i_s_axis_tvalid && en;

    uws_decoder u_dec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_take      (take),
        .i_action    (i_s_axis_tuser),
        .i_data_byte (i_s_axis_tdata),
        .o_evt       (evt)
    );

    uws_word_counter #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_words (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_evt    (evt),
        .o_valid  (out_valid),
        .o_result (result)
    );

    assign o_m_axis_tvalid = out_valid;
    assign o_m_axis_tdata  = {result.consonant_end_words,
                              result.vowel_start_words,
                              result.word_total};

endmodule

`default_nettype wire

### sv/uws_decoder.sv
`default_nettype none

module uws_decoder (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_take,
    input  wire logic           i_action,
    input  wire logic [7:0]     i_data_byte,
    output uws_pkg::t_cp_evt    o_evt
);

    logic [1:0]                  r_pending, n_pending;
    logic [uws_pkg::CP_W-1:0]    r_acc, n_acc;
    uws_pkg::t_cp_evt            r_evt, n_evt;

    // sequence assembly and event generation for one byte
    always_comb begin
        n_pending    = r_pending;
        n_acc        = r_acc;
        n_evt.valid  = 1'b0;
        n_evt.is_end = 1'b0;
        n_evt.cp     = '0;
        if (i_take) begin
            if (i_action) begin
                n_pending    = '0;
                n_acc        = '0;
                n_evt.valid  = 1'b1;
                n_evt.is_end = 1'b1;
            end else if (r_pending != 2'd0) begin
                // continuation byte, taken unchecked
                n_acc     = {r_acc[uws_pkg::CP_W-7:0], i_data_byte[5:0]};
                n_pending = r_pending - 2'd1;
                if (r_pending == 2'd1) begin
                    n_evt.valid = 1'b1;
                    n_evt.cp    = n_acc;
                end
            end else if (i_data_byte[7] == 1'b0) begin
                n_evt.valid = 1'b1;
                n_evt.cp    = {{(uws_pkg::CP_W-8){1'b0}}, i_data_byte};
            end else if (i_data_byte[7:5] == 3'b110) begin
                n_acc     = {{(uws_pkg::CP_W-5){1'b0}}, i_data_byte[4:0]};
                n_pending = 2'd1;
            end else if (i_data_byte[7:4] == 4'b1110) begin
                n_acc     = {{(uws_pkg::CP_W-4){1'b0}}, i_data_byte[3:0]};
                n_pending = 2'd2;
            end else if (i_data_byte[7:3] == 5'b11110) begin
                n_acc     = {{(uws_pkg::CP_W-3){1'b0}}, i_data_byte[2:0]};
                n_pending = 2'd3;
            end
            // invalid lead byte produces no event and leaves the state unchanged
        end
    end

    // decoder state and event register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_acc     <= '0;
            r_evt     <= '0;
        end else if (i_en) begin
            r_pending <= n_pending;
            r_acc     <= n_acc;
            r_evt     <= n_evt;
        end
    end

    assign o_evt = r_evt;

endmodule

`default_nettype wire

### sv/uws_word_counter.sv
`default_nettype none

module uws_word_counter #(
    parameter int unsigned COUNT_WIDTH = uws_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire uws_pkg::t_cp_evt i_evt,
    output logic                o_valid,
    output uws_pkg::t_result    o_result
);

    localparam logic [uws_pkg::CP_W-1:0] CP_APOS     = 21'h27;
    localparam logic [uws_pkg::CP_W-1:0] CP_LSQUOTE  = 21'd8216;
    localparam logic [uws_pkg::CP_W-1:0] CP_RSQUOTE  = 21'd8217;
    localparam logic [uws_pkg::CP_W-1:0] CP_UNDER    = 21'd95;
    localparam logic [uws_pkg::CP_W-1:0] CP_CCED_LO  = 21'hE7;
    localparam logic [uws_pkg::CP_W-1:0] CP_CCED_UP  = 21'hC7;
    localparam logic [uws_pkg::CP_W-1:0] CP_ENDASH   = 21'd8211;
    localparam logic [uws_pkg::CP_W-1:0] CP_EMDASH   = 21'd8212;
    localparam logic [uws_pkg::CP_W-1:0] CP_LDQUOTE  = 21'd8220;
    localparam logic [uws_pkg::CP_W-1:0] CP_RDQUOTE  = 21'd8221;
    localparam logic [uws_pkg::CP_W-1:0] CP_ELLIPSIS = 21'd8230;
    localparam logic [uws_pkg::CP_W-1:0] CP_LGUILL   = 21'hAB;
    localparam logic [uws_pkg::CP_W-1:0] CP_RGUILL   = 21'hBB;

    function automatic logic in_rng(input logic [uws_pkg::CP_W-1:0] c,
                                    input logic [uws_pkg::CP_W-1:0] lo,
                                    input logic [uws_pkg::CP_W-1:0] hi);
        return (c >= lo) && (c <= hi);
    endfunction

    // plain and Latin-1 accented a, e, i, o, u
    function automatic logic is_vowel(input logic [uws_pkg::CP_W-1:0] c);
        return c == 21'h61 || c == 21'h41 || in_rng(c, 21'hC0, 21'hC6)
            || in_rng(c, 21'hE0, 21'hE6)
            || c == 21'h65 || c == 21'h45 || in_rng(c, 21'hC8, 21'hCB)
            || in_rng(c, 21'hE8, 21'hEB)
            || c == 21'h69 || c == 21'h49 || in_rng(c, 21'hCC, 21'hCF)
            || in_rng(c, 21'hEC, 21'hEF)
            || c == 21'h6F || c == 21'h4F || in_rng(c, 21'hD2, 21'hD6)
            || in_rng(c, 21'hF2, 21'hF6)
            || c == 21'h75 || c == 21'h55 || in_rng(c, 21'hD9, 21'hDC)
            || in_rng(c, 21'hF9, 21'hFC);
    endfunction

    function automatic logic is_consonant(input logic [uws_pkg::CP_W-1:0] c);
        logic letter;
        letter = in_rng(c, 21'h41, 21'h5A) || in_rng(c, 21'h61, 21'h7A);
        return (letter && !is_vowel(c)) || c == CP_CCED_LO || c == CP_CCED_UP;
    endfunction

    function automatic logic is_delim(input logic [uws_pkg::CP_W-1:0] c);
        return c == 21'h20 || c == 21'h09 || c == 21'h0A || c == 21'h0D
            || c == 21'h2D || c == 21'h22 || c == 21'h5B || c == 21'h5D
            || c == 21'h28 || c == 21'h29 || c == 21'h2E || c == 21'h2C
            || c == 21'h3B || c == 21'h21 || c == 21'h3F || c == 21'h3A
            || c == CP_LGUILL || c == CP_RGUILL || c == CP_ELLIPSIS
            || c == CP_ENDASH || c == CP_EMDASH || c == CP_LDQUOTE
            || c == CP_RDQUOTE;
    endfunction

    function automatic logic is_apos(input logic [uws_pkg::CP_W-1:0] c);
        return c == CP_APOS || c == CP_LSQUOTE || c == CP_RSQUOTE;
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (&v) ? v : v + COUNT_WIDTH'(1);
    endfunction

    logic                   r_inside, n_inside;
    logic                   r_last_cons, n_last_cons;
    logic [COUNT_WIDTH-1:0] r_words, n_words;
    logic [COUNT_WIDTH-1:0] r_vstart, n_vstart;
    logic [COUNT_WIDTH-1:0] r_cend, n_cend;
    logic                   r_out_valid;
    uws_pkg::t_result       r_out, n_out;

    logic c_vowel, c_cons, c_word, c_delim, c_apos;

    // character classes of the incoming code point
    always_comb begin
        c_vowel = is_vowel(i_evt.cp);
        c_cons  = is_consonant(i_evt.cp);
        c_word  = in_rng(i_evt.cp, 21'd48, 21'd57) || c_vowel || c_cons
                  || i_evt.cp == CP_UNDER;
        c_delim = is_delim(i_evt.cp);
        c_apos  = is_apos(i_evt.cp);
    end

    // clamp or zero-extend counts to the 32-bit result fields
    generate
        if (COUNT_WIDTH > uws_pkg::OUT_W) begin : g_clamp
            always_comb begin
                n_out.word_total = (|r_words[COUNT_WIDTH-1:uws_pkg::OUT_W])
                    ? '1 : r_words[uws_pkg::OUT_W-1:0];
                n_out.vowel_start_words = (|r_vstart[COUNT_WIDTH-1:uws_pkg::OUT_W])
                    ? '1 : r_vstart[uws_pkg::OUT_W-1:0];
                n_out.consonant_end_words = (|r_cend[COUNT_WIDTH-1:uws_pkg::OUT_W])
                    ? '1 : r_cend[uws_pkg::OUT_W-1:0];
            end
        end else begin : g_extend
            always_comb begin
                n_out.word_total          = uws_pkg::OUT_W'(r_words);
                n_out.vowel_start_words   = uws_pkg::OUT_W'(r_vstart);
                n_out.consonant_end_words = uws_pkg::OUT_W'(r_cend);
            end
        end
    endgenerate

    // word machine
    always_comb begin
        n_inside    = r_inside;
        n_last_cons = r_last_cons;
        n_words     = r_words;
        n_vstart    = r_vstart;
        n_cend      = r_cend;
        if (i_evt.valid) begin
            if (i_evt.is_end) begin
                n_inside    = 1'b0;
                n_last_cons = 1'b0;
                n_words     = '0;
                n_vstart    = '0;
                n_cend      = '0;
            end else if (!r_inside) begin
                if (c_word) begin
                    n_inside    = 1'b1;
                    n_words     = sat_inc(r_words);
                    n_last_cons = c_cons;
                    if (c_vowel) begin
                        n_vstart = sat_inc(r_vstart);
                    end
                end
            end else if (c_word || c_apos) begin
                n_last_cons = c_cons;
            end else if (c_delim) begin
                n_inside = 1'b0;
                if (r_last_cons) begin
                    n_cend = sat_inc(r_cend);
                end
            end
        end
    end

    // word state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside    <= 1'b0;
            r_last_cons <= 1'b0;
            r_words     <= '0;
            r_vstart    <= '0;
            r_cend      <= '0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_inside    <= n_inside;
            r_last_cons <= n_last_cons;
            r_words     <= n_words;
            r_vstart    <= n_vstart;
            r_cend      <= n_cend;
            r_out_valid <= i_evt.valid && i_evt.is_end;
        end
    end

    // result register, loaded on end of text
    always_ff @(posedge i_clk) begin
        if (i_en && i_evt.valid && i_evt.is_end) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire
